// ----- rtl/core/mrbpa_pkg.sv -----
package mrbpa_pkg;

  localparam int MAX_RANGES_DEF = 8;
  localparam int FRAME_BITS_DEF = 40;
  localparam int FIELD_W        = 41;
  localparam int ADDR_W         = 52;
  localparam int PAGE_SHIFT     = 12;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_ALLOC = 2'd1,
    CMD_SEAL  = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NOMEM  = 2'd1,
    ST_SEALED = 2'd2
  } status_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic do_load;
    logic do_seal;
    logic rd_idx;
    logic rd_scan;
    logic scan_step;
    logic commit;
    logic res_fail;
    logic res_sealed;
    logic res_zero;
    logic res_rd;
    logic push;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    cmd_t cmd;
    logic idx_ok;
    logic sealed;
    logic scan_empty;
    logic scan_last;
    logic fit;
    logic out_busy;
  } sts_t;

endpackage

// ----- rtl/core/mrbpa_ram.sv -----
module mrbpa_ram #(
  parameter int W  = 8,
  parameter int D  = 8,
  parameter int AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/mrbpa_ctrl.sv -----
module mrbpa_ctrl
  import mrbpa_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output ctl_t ctl
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DISP = 4'b0010,
    S_EVAL = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctl.accept = 1'b1;
          state_nxt  = S_DISP;
        end
      end
      S_DISP: begin
        case (sts.cmd)
          CMD_LOAD: begin
            ctl.do_load = 1'b1;
            state_nxt   = S_FIN;
          end
          CMD_SEAL, CMD_READ: begin
            ctl.do_seal = (sts.cmd == CMD_SEAL);
            if (sts.idx_ok) begin
              ctl.rd_idx = 1'b1;
              state_nxt  = S_EVAL;
            end else begin
              ctl.res_zero = 1'b1;
              state_nxt    = S_FIN;
            end
          end
          CMD_ALLOC: begin
            if (sts.sealed) begin
              ctl.res_sealed = 1'b1;
              state_nxt      = S_FIN;
            end else if (sts.scan_empty) begin
              ctl.res_fail = 1'b1;
              state_nxt    = S_FIN;
            end else begin
              ctl.rd_scan = 1'b1;
              state_nxt   = S_EVAL;
            end
          end
          default: begin
            state_nxt = S_FIN;
          end
        endcase
      end
      S_EVAL: begin
        if (sts.cmd == CMD_ALLOC) begin
          if (sts.fit) begin
            ctl.commit = 1'b1;
            state_nxt  = S_FIN;
          end else if (sts.scan_last) begin
            ctl.res_fail = 1'b1;
            state_nxt    = S_FIN;
          end else begin
            ctl.scan_step = 1'b1;
            ctl.rd_scan   = 1'b1;
          end
        end else begin
          ctl.res_rd = 1'b1;
          state_nxt  = S_FIN;
        end
      end
      S_FIN: begin
        if (!sts.out_busy) begin
          ctl.push  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/core/mrbpa_dp.sv -----
module mrbpa_dp
  import mrbpa_pkg::*;
#(
  parameter int MAX_RANGES = MAX_RANGES_DEF,
  parameter int FRAME_BITS = FRAME_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ctl_t               ctl,
  output sts_t               sts,
  input  logic               cfg_valid,
  input  logic [3:0]         cfg_active_ranges,
  input  logic [1:0]         in_cmd,
  input  logic [2:0]         in_range_index,
  input  logic [FIELD_W-1:0] in_start_frame,
  input  logic [FIELD_W-1:0] in_end_frame,
  input  logic [FIELD_W-1:0] in_page_count,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_status,
  output logic [ADDR_W-1:0]  out_base_address,
  output logic [FIELD_W-1:0] out_range_cursor_out,
  output logic [FIELD_W-1:0] out_used_pages
);

  localparam int CW = (FRAME_BITS + 1 < FIELD_W) ? FRAME_BITS + 1 : FIELD_W;
  localparam int AW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int XW = FIELD_W + 1;
  localparam logic [6:0] MAXR = 7'(MAX_RANGES);

  cmd_t               cmd_r;
  logic [2:0]         idx_r;
  logic [CW-1:0]      start_r;
  logic [CW-1:0]      end_r;
  logic [FIELD_W-1:0] cnt_r;
  logic [3:0]         j_r, j_nxt;
  logic [FIELD_W-1:0] used_r, used_nxt;
  logic               sealed_r;
  logic [3:0]         active_r;

  status_t            res_status_r;
  logic [ADDR_W-1:0]  res_base_r;
  logic [FIELD_W-1:0] res_cur_r;

  logic               out_valid_r;
  status_t            out_status_r;
  logic [ADDR_W-1:0]  out_base_r;
  logic [FIELD_W-1:0] out_cur_r;
  logic [FIELD_W-1:0] out_used_r;

  logic [6:0]    idx_w, act_w, rd_w, wr_w;
  logic [3:0]    n_act, rd_j, wr_j;
  logic          idx_ok;
  logic [AW-1:0] raddr, waddr;
  logic          re, st_we, cu_we;
  logic [CW-1:0] cu_wdata;
  logic [CW-1:0] start_q, cur_q;
  logic [XW-1:0] cur_x, start_x, cnt_x, lim_x, diff_x, nc_x, sum_x, end_x;
  logic [CW-1:0] new_cur;
  logic          fit;

  // slot selection
  assign idx_w  = {4'd0, idx_r};
  assign idx_ok = (idx_w < MAXR);
  assign act_w  = {3'd0, active_r};
  assign n_act  = (act_w > MAXR) ? MAXR[3:0] : active_r;
  assign j_nxt  = ctl.accept ? n_act : (ctl.scan_step ? 4'(j_r - 4'd1) : j_r);
  assign rd_j   = 4'(j_nxt - 4'd1);
  assign wr_j   = 4'(j_r - 4'd1);
  assign rd_w   = {3'd0, rd_j};
  assign wr_w   = {3'd0, wr_j};

  assign re       = ctl.rd_idx | ctl.rd_scan;
  assign raddr    = ctl.rd_idx ? idx_w[AW-1:0] : rd_w[AW-1:0];
  assign waddr    = ctl.do_load ? idx_w[AW-1:0] : wr_w[AW-1:0];
  assign st_we    = ctl.do_load & idx_ok;
  assign cu_we    = (ctl.do_load & idx_ok) | ctl.commit;
  assign cu_wdata = ctl.do_load ? end_r : new_cur;

  mrbpa_ram #(.W(CW), .D(MAX_RANGES), .AW(AW)) u_starts (
    .clk   (clk),
    .we    (st_we),
    .waddr (waddr),
    .wdata (start_r),
    .re    (re),
    .raddr (raddr),
    .rdata (start_q)
  );

  mrbpa_ram #(.W(CW), .D(MAX_RANGES), .AW(AW)) u_cursors (
    .clk   (clk),
    .we    (cu_we),
    .waddr (waddr),
    .wdata (cu_wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (cur_q)
  );

  // fit check and carve
  assign cur_x   = {{(XW-CW){1'b0}}, cur_q};
  assign start_x = {{(XW-CW){1'b0}}, start_q};
  assign end_x   = {{(XW-CW){1'b0}}, end_r};
  assign cnt_x   = {1'b0, cnt_r};
  assign lim_x   = start_x + cnt_x;
  assign fit     = (cnt_r == '0) || (cur_x >= lim_x);
  assign diff_x  = cur_x - cnt_x;
  assign new_cur = diff_x[CW-1:0];
  assign nc_x    = {{(XW-CW){1'b0}}, new_cur};
  assign sum_x   = {1'b0, used_r} + cnt_x;
  assign used_nxt = sum_x[FIELD_W] ? '1 : sum_x[FIELD_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
      sealed_r <= 1'b0;
      used_r   <= '0;
      j_r      <= '0;
    end else begin
      if (cfg_valid) begin
        active_r <= cfg_active_ranges;
      end
      if (ctl.do_load) begin
        sealed_r <= 1'b0;
        used_r   <= '0;
      end else if (ctl.do_seal) begin
        sealed_r <= 1'b1;
      end else if (ctl.commit) begin
        used_r <= used_nxt;
      end
      j_r <= j_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      cmd_r   <= cmd_t'(in_cmd);
      idx_r   <= in_range_index;
      start_r <= in_start_frame[CW-1:0];
      end_r   <= in_end_frame[CW-1:0];
      cnt_r   <= in_page_count;
    end
    if (ctl.do_load) begin
      res_status_r <= ST_OK;
      res_base_r   <= '0;
      res_cur_r    <= idx_ok ? end_x[FIELD_W-1:0] : '0;
    end else if (ctl.res_zero) begin
      res_status_r <= ST_OK;
      res_base_r   <= '0;
      res_cur_r    <= '0;
    end else if (ctl.res_rd) begin
      res_status_r <= ST_OK;
      res_base_r   <= '0;
      res_cur_r    <= cur_x[FIELD_W-1:0];
    end else if (ctl.commit) begin
      res_status_r <= ST_OK;
      res_base_r   <= {nc_x[ADDR_W-PAGE_SHIFT-1:0], {PAGE_SHIFT{1'b0}}};
      res_cur_r    <= nc_x[FIELD_W-1:0];
    end else if (ctl.res_fail) begin
      res_status_r <= ST_NOMEM;
      res_base_r   <= '0;
      res_cur_r    <= '0;
    end else if (ctl.res_sealed) begin
      res_status_r <= ST_SEALED;
      res_base_r   <= '0;
      res_cur_r    <= '0;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.push) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      out_status_r <= res_status_r;
      out_base_r   <= res_base_r;
      out_cur_r    <= res_cur_r;
      out_used_r   <= used_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_status           = out_status_r;
  assign out_base_address     = out_base_r;
  assign out_range_cursor_out = out_cur_r;
  assign out_used_pages       = out_used_r;

  assign sts.cmd        = cmd_r;
  assign sts.idx_ok     = idx_ok;
  assign sts.sealed     = sealed_r;
  assign sts.scan_empty = (j_r == 4'd0);
  assign sts.scan_last  = (j_r == 4'd1);
  assign sts.fit        = fit;
  assign sts.out_busy   = out_valid_r & ~out_ready;

  a_commit_fits: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.commit |-> fit)
    else $error("allocation committed on a slot without room");

  a_load_reopens: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.do_load |=> (used_r == '0) && !sealed_r)
    else $error("load did not reopen the allocator");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    {3'd0, j_r} <= MAXR)
    else $error("scan counter beyond slot count");

  a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.push |-> !(out_valid_r && !out_ready))
    else $error("result word overwritten while stalled");

endmodule

// ----- rtl/core/multi_range_bump_page_allocator_core.sv -----
// Top-down bump page allocator over up to MAX_RANGES frame ranges held in two small RAMs
// (start and cursor per slot). Load answers without a RAM read; read and seal, for a valid
// index, go through one registered RAM read; allocate examines k slots, one per cycle from
// the highest active slot down (k is 1 to min(active_ranges, MAX_RANGES); a sealed
// allocator or no active slot answers without examining any slot).
// One word is worked on at a time; the next word is taken while a finished result still
// waits in the output register. cfg_active_ranges may be written only while the block is idle.
module multi_range_bump_page_allocator_core
  import mrbpa_pkg::*;
#(
  parameter int MAX_RANGES = MAX_RANGES_DEF,
  parameter int FRAME_BITS = FRAME_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [3:0]         cfg_active_ranges,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_cmd,
  input  logic [2:0]         in_range_index,
  input  logic [FIELD_W-1:0] in_start_frame,
  input  logic [FIELD_W-1:0] in_end_frame,
  input  logic [FIELD_W-1:0] in_page_count,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_status,
  output logic [ADDR_W-1:0]  out_base_address,
  output logic [FIELD_W-1:0] out_range_cursor_out,
  output logic [FIELD_W-1:0] out_used_pages
);

  ctl_t ctl;
  sts_t sts;

  assign cfg_ready = 1'b1;

  mrbpa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  mrbpa_dp #(
    .MAX_RANGES (MAX_RANGES),
    .FRAME_BITS (FRAME_BITS)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .ctl                  (ctl),
    .sts                  (sts),
    .cfg_valid            (cfg_valid),
    .cfg_active_ranges    (cfg_active_ranges),
    .in_cmd               (in_cmd),
    .in_range_index       (in_range_index),
    .in_start_frame       (in_start_frame),
    .in_end_frame         (in_end_frame),
    .in_page_count        (in_page_count),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_status           (out_status),
    .out_base_address     (out_base_address),
    .out_range_cursor_out (out_range_cursor_out),
    .out_used_pages       (out_used_pages)
  );

endmodule
